// ===== rtl/fpst_pkg.sv =====
// Package with the shared constants and types of the Fenwick prefix-sum table.
`timescale 1ns / 1ps
package fpst_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = 11;
  localparam int NODE_W = POS_W + 1;
  localparam int SIZE_W = 11;
  localparam int DATA_W = 32;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_RESULT = 4'b1000
  } walk_state_t;

endpackage

// ===== rtl/fpst_if.sv =====
// Channel interfaces for the input items and the prefix-sum results.
`timescale 1ns / 1ps
interface fpst_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic        [fpst_pkg::POS_W-1:0]  position;
  logic signed [fpst_pkg::DATA_W-1:0] delta;

  modport source (output valid, output action, output position, output delta, input ready);
  modport sink   (input valid, input action, input position, input delta, output ready);
endinterface

interface fpst_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fpst_pkg::DATA_W-1:0] prefix_sum;

  modport source (output valid, output prefix_sum, input ready);
  modport sink   (input valid, input prefix_sum, output ready);
endinterface

// ===== rtl/fpst_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module fpst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fpst_walker.sv =====
// Tree walker: clearing pass, add and query walks over the node memory, result register.
`timescale 1ns / 1ps
module fpst_walker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fpst_pkg::SIZE_W-1:0]   size_in_use,
  fpst_in_if.sink                       in_chan,
  fpst_out_if.source                    out_chan,
  output fpst_pkg::mem_req_t            mem_req,
  input  logic [fpst_pkg::DATA_W-1:0]   mem_rdata
);

  fpst_pkg::walk_state_t state_r, state_nxt;

  logic [fpst_pkg::ADDR_W-1:0] clr_r, clr_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        action_r, action_nxt;
  logic [fpst_pkg::NODE_W-1:0] pos_r, pos_nxt;
  logic [fpst_pkg::SIZE_W-1:0] limit_r, limit_nxt;
  logic [fpst_pkg::DATA_W-1:0] delta_r, delta_nxt;
  logic [fpst_pkg::DATA_W-1:0] acc_r, acc_nxt;
  logic [fpst_pkg::ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [fpst_pkg::DATA_W-1:0] out_sum_r, out_sum_nxt;

  logic                        is_add;
  logic                        in_tree;
  logic                        active;
  logic [fpst_pkg::NODE_W-1:0] lsb;
  logic [fpst_pkg::DATA_W-1:0] pend_data;
  logic [fpst_pkg::NODE_W-1:0] node_idx;

  assign in_chan.ready       = (state_r == fpst_pkg::ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.prefix_sum = out_sum_r;

  always_comb begin
    is_add    = (action_r == fpst_pkg::ACT_ADD);
    lsb       = pos_r & (~pos_r + fpst_pkg::NODE_W'(1));
    in_tree   = (pos_r <= fpst_pkg::NODE_W'(fpst_pkg::DEPTH));
    active    = (pos_r != '0) &&
                (!is_add || (pos_r <= {1'b0, limit_r}));
    pend_data = rd_pend_r ? mem_rdata : '0;
    node_idx  = pos_r - fpst_pkg::NODE_W'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    action_nxt    = action_r;
    pos_nxt       = pos_r;
    limit_nxt     = limit_r;
    delta_nxt     = delta_r;
    acc_nxt       = acc_r;
    wr_addr_nxt   = wr_addr_r;
    out_sum_nxt   = out_sum_r;
    mem_req       = '0;

    case (state_r)
      fpst_pkg::ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        clr_nxt       = clr_r + fpst_pkg::ADDR_W'(1);
        if (clr_r == fpst_pkg::ADDR_W'(fpst_pkg::DEPTH - 1)) begin
          state_nxt = fpst_pkg::ST_IDLE;
        end
      end
      fpst_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          action_nxt = in_chan.action;
          pos_nxt    = {1'b0, in_chan.position};
          delta_nxt  = in_chan.delta;
          acc_nxt    = '0;
          if (size_in_use > fpst_pkg::SIZE_W'(fpst_pkg::DEPTH)) begin
            limit_nxt = fpst_pkg::SIZE_W'(fpst_pkg::DEPTH);
          end else begin
            limit_nxt = size_in_use;
          end
          state_nxt = fpst_pkg::ST_WALK;
        end
      end
      fpst_pkg::ST_WALK: begin
        // Data read for the previous node arrives now; the next node's read
        // goes out in the same cycle, so the walk covers one node per cycle.
        if (is_add && rd_pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = wr_addr_r;
          mem_req.wdata = mem_rdata + delta_r;
        end
        if (!is_add) begin
          acc_nxt = acc_r + pend_data;
        end
        if (active) begin
          pos_nxt = is_add ? (pos_r + lsb) : (pos_r - lsb);
          // Query nodes beyond the tree count as zero and are stepped over.
          if (is_add || in_tree) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = node_idx[fpst_pkg::ADDR_W-1:0];
            wr_addr_nxt   = node_idx[fpst_pkg::ADDR_W-1:0];
            rd_pend_nxt   = 1'b1;
          end
        end else begin
          state_nxt = is_add ? fpst_pkg::ST_IDLE : fpst_pkg::ST_RESULT;
        end
      end
      fpst_pkg::ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = acc_r;
          state_nxt     = fpst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpst_pkg::ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpst_pkg::ST_CLEAR;
      clr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r  <= action_nxt;
    pos_r     <= pos_nxt;
    limit_r   <= limit_nxt;
    delta_r   <= delta_nxt;
    acc_r     <= acc_nxt;
    wr_addr_r <= wr_addr_nxt;
    out_sum_r <= out_sum_nxt;
  end

endmodule

// ===== rtl/fenwick_prefix_sum_table.sv =====
// Top level of the Fenwick prefix-sum table: size register, node memory and walker.
//
// Usage: the input channel carries one transaction per item: action (0 add,
// 1 prefix-sum query), a 1-based position and a signed 32-bit delta. An add
// adds delta into every tree node on the upward walk and returns nothing; a
// query returns one transaction on the output channel with the sum of
// positions 1..position, wrapping modulo 2^32. cfg_we/cfg_wdata write the
// active size; adds beyond it are dropped. Write it only while idle.
// Throughput: one item at a time. The next item is accepted once the walk
// over the tree nodes, at most 11 of them, is done and, for a query, once
// the result register has been loaded. The walk is bound by the single read
// port of the node memory, one node per cycle.
// Reset: a clearing pass writes zero to all 1024 nodes; no item is accepted
// meanwhile, configuration writes are.
// When the receiver stalls, the result waits in the output register and the
// next item is still accepted and walked; a further query then holds until
// the register is free.
`timescale 1ns / 1ps
module fenwick_prefix_sum_table (
  input  logic                        clk,
  input  logic                        rst_n,
  fpst_in_if.sink                     in_chan,
  fpst_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [fpst_pkg::SIZE_W-1:0] cfg_wdata
);

  logic [fpst_pkg::SIZE_W-1:0] size_r;
  fpst_pkg::mem_req_t          mem_req;
  logic [fpst_pkg::DATA_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= fpst_pkg::SIZE_W'(fpst_pkg::DEPTH);
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  fpst_ram #(
    .WIDTH (fpst_pkg::DATA_W),
    .DEPTH (fpst_pkg::DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  fpst_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .size_in_use (size_r),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

endmodule
